### src/csl_pkg.sv
package csl_pkg;

  // Fixed field widths of the request and result transactions.
  localparam int POS_W   = 5;
  localparam int VAL_W   = 32;
  localparam int CNT_W   = 5;
  localparam int LIMIT_W = 5;
  localparam int KIND_W  = 2;

  // Packed stream widths; the data widths are rounded up to whole bytes.
  localparam int IN_DATA_W  = 40;
  localparam int IN_USER_W  = KIND_W;
  localparam int OUT_DATA_W = 40;
  localparam int OUT_USER_W = 1;

  // Capacity limit after reset.
  localparam logic [LIMIT_W-1:0] LIMIT_RST = 5'd16;

  // Request kinds.
  typedef enum logic [KIND_W-1:0] {
    KIND_APPEND    = 2'd0,
    KIND_DELETE    = 2'd1,
    KIND_READ      = 2'd2,
    KIND_OVERWRITE = 2'd3
  } kind_t;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic wr;   // write the cell whose index matches sel_idx
    logic del;  // shift down every cell from sel_idx up to the last one held
    logic rd;   // drive the matching cell's contents onto the read bus
  } cell_ctl_t;

endpackage

### src/compacting_sequential_list.sv
// Channel  Direction  Ports                          Contents
// in       slave      in_tvalid/in_tready/in_tdata   request: kind, position, value
// out      master     out_tvalid/out_tready/out_tdata result: ok, read_value, count
// cfg      write only cfg_wr_en/cfg_wr_data          capacity_limit
//
// A delete shifts the cells above the deleted position down in the cycle it is
// accepted, so one transaction can be accepted per cycle unless a result stalls.
// The result sits in an output register; a new request is taken when that register
// is empty or being emptied in the same cycle, so a stalled result holds the input.
// Reset (rst_n low, synchronous) empties the list and sets the limit to 16; entry
// contents are not cleared.
module compacting_sequential_list #(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // Request stream.
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [csl_pkg::IN_DATA_W-1:0]      in_tdata,   // position[4:0], value[36:5], zeros
  input  logic [csl_pkg::IN_USER_W-1:0]      in_tuser,   // kind[1:0]
  // Result stream.
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [csl_pkg::OUT_DATA_W-1:0]     out_tdata,  // read_value[31:0], count[36:32], zeros
  output logic [csl_pkg::OUT_USER_W-1:0]     out_tuser,  // ok[0]
  // Configuration write.
  input  logic                               cfg_wr_en,
  input  logic [csl_pkg::LIMIT_W-1:0]        cfg_wr_data
);

  localparam int CNT_IW = $clog2(CAPACITY + 1);
  localparam int CMP_W  = (CNT_IW > csl_pkg::POS_W) ? CNT_IW : csl_pkg::POS_W;
  localparam int EXT_W  = (DATA_WIDTH > csl_pkg::VAL_W) ? DATA_WIDTH : csl_pkg::VAL_W;
  // Positions are five bits wide, so only the lowest cells can ever be read.
  localparam int RD_CELLS = (CAPACITY < 32) ? CAPACITY : 32;

  logic [csl_pkg::LIMIT_W-1:0] limit_r;
  logic [CNT_IW-1:0]           count_r;
  logic [CNT_IW-1:0]           count_nxt;
  logic                        out_valid_r;
  logic                        out_ok_r;
  logic [csl_pkg::VAL_W-1:0]   out_rd_r;
  logic [csl_pkg::CNT_W-1:0]   out_cnt_r;

  csl_pkg::kind_t              kind;
  logic [csl_pkg::POS_W-1:0]   position;
  logic [csl_pkg::VAL_W-1:0]   value;
  logic                        acc;
  logic [CMP_W-1:0]            count_x;
  logic [CMP_W-1:0]            pos_x;
  logic [CMP_W-1:0]            limit_x;
  logic [CMP_W-1:0]            lim_eff;
  logic                        in_range;
  logic                        app_ok;
  logic                        ok_c;
  csl_pkg::cell_ctl_t          ctl;
  logic [CMP_W-1:0]            sel_idx;
  logic [EXT_W-1:0]            val_ext;
  logic [DATA_WIDTH-1:0]       wdata;
  logic [DATA_WIDTH-1:0]       cell_data [CAPACITY];
  logic [DATA_WIDTH-1:0]       cell_rd   [CAPACITY];
  logic [DATA_WIDTH-1:0]       rd_or;
  logic [EXT_W-1:0]            rd_ext;

  // Unpack the request transaction.
  assign kind     = csl_pkg::kind_t'(in_tuser[csl_pkg::KIND_W-1:0]);
  assign position = in_tdata[csl_pkg::POS_W-1:0];
  assign value    = in_tdata[csl_pkg::POS_W +: csl_pkg::VAL_W];

  assign in_tready = !out_valid_r || out_tready;
  assign acc       = in_tvalid && in_tready;

  // Range checks against the count and the effective limit.
  assign count_x  = CMP_W'(count_r);
  assign pos_x    = CMP_W'(position);
  assign limit_x  = CMP_W'(limit_r);
  assign lim_eff  = (limit_x > CMP_W'(CAPACITY)) ? CMP_W'(CAPACITY) : limit_x;
  assign in_range = pos_x < count_x;
  assign app_ok   = count_x < lim_eff;

  always_comb begin
    case (kind)
      csl_pkg::KIND_APPEND: ok_c = app_ok;
      csl_pkg::KIND_DELETE,
      csl_pkg::KIND_READ,
      csl_pkg::KIND_OVERWRITE: ok_c = in_range;
      default: ok_c = 1'b0;
    endcase
  end

  // Command for the cell chain.
  always_comb begin
    ctl.wr  = acc && ok_c &&
              (kind == csl_pkg::KIND_APPEND || kind == csl_pkg::KIND_OVERWRITE);
    ctl.del = acc && ok_c && (kind == csl_pkg::KIND_DELETE);
    ctl.rd  = ok_c && (kind == csl_pkg::KIND_READ);
  end

  assign sel_idx = (kind == csl_pkg::KIND_APPEND) ? count_x : pos_x;
  assign val_ext = EXT_W'(value);
  assign wdata   = val_ext[DATA_WIDTH-1:0];

  // The chain of storage cells; on a delete the cells in the compacting part take their upper neighbor's entry.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] nbr;
    if (i + 1 < CAPACITY) begin : g_mid
      assign nbr = cell_data[i+1];
    end else begin : g_top
      assign nbr = cell_data[i];
    end
    csl_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .CMP_W      (CMP_W),
      .INDEX      (i)
    ) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .sel_idx  (sel_idx),
      .cnt      (count_x),
      .wdata    (wdata),
      .nbr_data (nbr),
      .data_out (cell_data[i]),
      .rd_data  (cell_rd[i])
    );
  end

  // Only the addressed cell drives the read bus, so an OR collects it.
  always_comb begin
    rd_or = '0;
    for (int i = 0; i < RD_CELLS; i++) begin
      rd_or = rd_or | cell_rd[i];
    end
  end

  assign rd_ext = EXT_W'(rd_or);

  // Entry count update.
  always_comb begin
    count_nxt = count_r;
    if (acc && ok_c && kind == csl_pkg::KIND_APPEND) begin
      count_nxt = count_r + CNT_IW'(1);
    end else if (ctl.del) begin
      count_nxt = count_r - CNT_IW'(1);
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r     <= csl_pkg::LIMIT_RST;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        limit_r <= cfg_wr_data;
      end
      count_r <= count_nxt;
      if (acc) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (acc) begin
      out_ok_r  <= ok_c;
      out_rd_r  <= rd_ext[csl_pkg::VAL_W-1:0];
      out_cnt_r <= csl_pkg::CNT_W'(count_nxt);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_ok_r;
  assign out_tdata  = {{(csl_pkg::OUT_DATA_W - csl_pkg::VAL_W - csl_pkg::CNT_W){1'b0}},
                       out_cnt_r, out_rd_r};

`ifndef SYNTHESIS
  // The list never holds more entries than the built capacity.
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_IW'(CAPACITY))
    else $error("entry count above capacity");

  // A successful delete removes exactly one entry.
  a_delete_count: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.del |=> count_r == $past(count_r) - CNT_IW'(1))
    else $error("delete did not lower the count by one");

  // A refused request leaves the count unchanged.
  a_fail_stable: assert property (@(posedge clk) disable iff (!rst_n)
    acc && !ok_c |=> $stable(count_r))
    else $error("failed request changed the count");

  // A stalled result blocks new requests.
  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |-> !in_tready)
    else $error("request accepted while a result is stalled");
`endif

endmodule

### src/csl_cell.sv
module csl_cell #(
  parameter int DATA_WIDTH = 32,
  parameter int CMP_W      = 5,
  parameter int INDEX      = 0
) (
  input  logic                  clk,
  input  csl_pkg::cell_ctl_t    ctl,
  input  logic [CMP_W-1:0]      sel_idx,
  input  logic [CMP_W-1:0]      cnt,
  input  logic [DATA_WIDTH-1:0] wdata,
  input  logic [DATA_WIDTH-1:0] nbr_data,
  output logic [DATA_WIDTH-1:0] data_out,
  output logic [DATA_WIDTH-1:0] rd_data
);

  logic [DATA_WIDTH-1:0] data_r;
  logic [DATA_WIDTH-1:0] data_nxt;
  logic                  hit;
  logic                  shift;

  // This cell is addressed, or lies in the part of the list that compacts.
  assign hit   = (sel_idx == CMP_W'(INDEX));
  assign shift = (CMP_W'(INDEX) >= sel_idx) && (CMP_W'(INDEX + 1) < cnt);

  // Take new data on a write, or the upper neighbor's entry on a delete.
  always_comb begin
    data_nxt = data_r;
    if (ctl.wr && hit) begin
      data_nxt = wdata;
    end else if (ctl.del && shift) begin
      data_nxt = nbr_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_out = data_r;
  assign rd_data  = (ctl.rd && hit) ? data_r : '0;

endmodule
